// ===== rtl/ictf_pkg.sv =====
// Shared types, constants and the arctangent table of the tilt filter.
`default_nettype none
package ictf_pkg;

    localparam int unsigned RAW_W  = 16;
    localparam int unsigned ANG_W  = 19;
    localparam int unsigned INC_W  = 35;
    localparam int unsigned WV_W   = 37;
    localparam int unsigned DQ_W   = 60;
    localparam int unsigned DVS_W  = 24;
    localparam int unsigned MA_W   = 33;
    localparam int unsigned MB_W   = 25;
    localparam int unsigned MP_W   = 58;
    localparam int unsigned SQ_W   = 48;
    localparam int unsigned CR_W   = 28;
    localparam int unsigned CZ_W   = 26;

    localparam logic [DVS_W-1:0] GYRO_DIV  = 24'd16384000;
    localparam logic [DVS_W-1:0] GYRO_HALF = 24'd8192000;
    localparam logic [DVS_W-1:0] DEG360_D  = 24'd368640;
    localparam logic [18:0]      DEG180_U  = 19'd184320;
    localparam logic signed [19:0] DEG360_S = 20'sd368640;
    localparam logic signed [ANG_W-1:0] DEG90 = 19'sd92160;

    localparam int unsigned CORD_STEPS = 19;
    localparam int unsigned DIV_STEPS  = 15;
    localparam int unsigned SQRT_STEPS = 24;

    typedef enum logic [3:0] {
        ST_IDLE, ST_GMUL1, ST_GMUL2, ST_GDIV, ST_SQ1, ST_SQ2, ST_SQ3, ST_SQRT,
        ST_CORD, ST_BMUL1, ST_BMUL2, ST_BSUM, ST_WRAP, ST_DONE
    } t_state;

    typedef enum logic [1:0] {WJ_GINT, WJ_DIFF, WJ_FUSE} t_wjob;

    typedef enum logic [2:0] {
        CFG_OFS_X, CFG_OFS_Y, CFG_OFS_Z, CFG_SCALE, CFG_AWGT, CFG_GWGT
    } t_cfg_idx;

    // Arctangent of 2^-i in degrees times 2^16.
    function automatic logic [22:0] atan_entry(input logic [4:0] idx);
        logic [22:0] v;
        case (idx)
            5'd0:  v = 23'd2949120;
            5'd1:  v = 23'd1740967;
            5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;
            5'd4:  v = 23'd234379;
            5'd5:  v = 23'd117265;
            5'd6:  v = 23'd58666;
            5'd7:  v = 23'd29335;
            5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/imu_complementary_tilt_filter_core.sv =====
// Complementary tilt filter: gyro integration, accelerometer tilt and blending.
`default_nettype none
// One IMU sample is taken per transaction when s_axis_tready is high. m_axis_tvalid
// rises when processing ends, and the result must be taken before the next sample
// is accepted; s_axis_tready returns the cycle after the result transaction. The
// time is set by one shared multiplier, one radix-16 constant divider (used for the
// gyro scaling and for every modulo-360 wrap, ten uses), a bit-serial square root
// and a 19-step CORDIC. Angles are signed, in 1/1024 degree.
module imu_complementary_tilt_filter_core import ictf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, elapsed_ms (16 each)
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fused_angle_x, fused_angle_y, heading_z, tilt_accel_x, tilt_accel_y,
    // integrated_x, integrated_y (19 each), 3 zero bits
    output logic [135:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [23:0]  i_cfg_wdata
);

    t_state r_state, n_state;
    logic [4:0] r_cnt;
    logic [1:0] r_sel;
    t_wjob r_wjob;
    logic r_neg;

    logic signed [RAW_W-1:0] r_accel [3];
    logic signed [RAW_W-1:0] r_rate [3];
    logic [RAW_W-1:0] r_ms;
    logic signed [RAW_W-1:0] r_ofs [3];
    logic [23:0] r_scale;
    logic [16:0] r_awgt, r_gwgt;

    logic signed [INC_W-1:0] r_inc [3];
    logic signed [ANG_W-1:0] r_gint [3];
    logic signed [ANG_W-1:0] r_fused [2];
    logic signed [ANG_W-1:0] r_tx, r_ty, r_d;

    logic signed [MP_W-1:0] r_prod, r_sacc;
    logic [31:0] r_sumsq;
    logic [DQ_W-1:0] r_dq;
    logic [DVS_W:0] r_rem;
    logic signed [WV_W-1:0] r_wval;
    logic [SQ_W-1:0] r_sq_n, r_sq_res, r_sq_bit;
    logic signed [CR_W-1:0] r_cx, r_cy;
    logic signed [CZ_W-1:0] r_cz;

    // Operand selection
    logic signed [16:0] diff;
    logic [16:0] diff_abs;
    logic signed [RAW_W-1:0] tw, tu, tv;
    logic signed [ANG_W-1:0] a_sel;
    logic signed [ANG_W:0] a_plus_d;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;
    logic cnt_clr;

    assign diff = 17'(r_rate[r_sel]) - 17'(r_ofs[r_sel]);
    assign diff_abs = diff[16] ? 17'(-diff) : diff;
    assign tw = r_sel[0] ? r_accel[0] : r_accel[1];
    assign tu = r_accel[2];
    assign tv = r_sel[0] ? r_accel[1] : r_accel[0];
    assign a_sel = r_sel[0] ? r_ty : r_tx;
    assign a_plus_d = 20'(a_sel) + 20'(r_d);
    assign mul_p = mul_a * mul_b;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_GMUL1;
            ST_GMUL1: n_state = ST_GMUL2;
            ST_GMUL2: n_state = ST_GDIV;
            ST_GDIV:  if (r_cnt == 5'(DIV_STEPS + 1)) n_state = ST_WRAP;
            ST_WRAP: begin
                if (r_cnt == 5'(DIV_STEPS + 1)) begin
                    case (r_wjob)
                        WJ_GINT: n_state = (r_sel == 2'd2) ? ST_SQ1 : ST_GMUL1;
                        WJ_DIFF: n_state = ST_BMUL1;
                        WJ_FUSE: n_state = r_sel[0] ? ST_DONE : ST_WRAP;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SQ1:   n_state = ST_SQ2;
            ST_SQ2:   n_state = ST_SQ3;
            ST_SQ3:   n_state = ST_SQRT;
            ST_SQRT:  if (r_cnt == 5'(SQRT_STEPS)) n_state = ST_CORD;
            ST_CORD: begin
                if (r_cnt == 5'(CORD_STEPS + 1)) n_state = r_sel[0] ? ST_WRAP : ST_SQ1;
            end
            ST_BMUL1: n_state = ST_BMUL2;
            ST_BMUL2: n_state = ST_BSUM;
            ST_BSUM:  n_state = ST_WRAP;
            ST_DONE:  if (m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs and unit control
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = (r_state == ST_DONE);
        cnt_clr = (n_state != r_state) ||
                  ((r_state == ST_WRAP) && (r_cnt == 5'(DIV_STEPS + 1)));
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_GMUL1: begin
                mul_a = $signed({16'b0, diff_abs});
                mul_b = $signed({9'b0, r_ms});
            end
            ST_GMUL2: begin
                mul_a = $signed({1'b0, r_prod[31:0]});
                mul_b = $signed({1'b0, r_scale});
            end
            ST_SQ1: begin
                mul_a = 33'(tu);
                mul_b = 25'(tu);
            end
            ST_SQ2: begin
                mul_a = 33'(tv);
                mul_b = 25'(tv);
            end
            ST_BMUL1: begin
                mul_a = 33'(a_sel);
                mul_b = $signed({8'b0, r_awgt});
            end
            ST_BMUL2: begin
                mul_a = 33'(a_plus_d);
                mul_b = $signed({8'b0, r_gwgt});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign m_axis_tdata = {3'b0, r_gint[1], r_gint[0], r_ty, r_tx, r_gint[2],
                           r_fused[1], r_fused[0]};

    // Constant divider, four quotient bits per cycle
    logic [DVS_W-1:0] dvs;
    logic [DQ_W-1:0] dv_q;
    logic [DVS_W:0] dv_r;
    assign dvs = (r_state == ST_GDIV) ? GYRO_DIV : DEG360_D;
    always_comb begin
        dv_q = r_dq;
        dv_r = r_rem;
        for (int k = 0; k < 4; k++) begin
            dv_r = {dv_r[DVS_W-1:0], dv_q[DQ_W-1]};
            dv_q = {dv_q[DQ_W-2:0], 1'b0};
            if (dv_r >= {1'b0, dvs}) begin
                dv_r = dv_r - {1'b0, dvs};
                dv_q[0] = 1'b1;
            end
        end
    end

    // Gyro increment from the quotient
    logic signed [INC_W-1:0] inc_val;
    assign inc_val = r_neg ? -$signed({1'b0, r_dq[33:0]}) : $signed({1'b0, r_dq[33:0]});

    // Wrap from the remainder modulo 360 degrees
    logic [WV_W-1:0] wmag;
    logic signed [19:0] wr_v, wr_s;
    logic signed [ANG_W-1:0] wr_res;
    assign wmag = r_wval[WV_W-1] ? WV_W'(-r_wval) : r_wval;
    assign wr_v = (r_rem[18:0] > DEG180_U) ? $signed({1'b0, r_rem[18:0]}) - DEG360_S
                                           : $signed({1'b0, r_rem[18:0]});
    assign wr_s = r_neg ? -wr_v : wr_v;
    assign wr_res = wr_s[ANG_W-1:0];

    // Square root step
    logic [SQ_W-1:0] sq_try;
    assign sq_try = r_sq_res + r_sq_bit;

    // CORDIC step
    logic [4:0] ci;
    logic signed [CR_W-1:0] cxs, cys;
    logic signed [CZ_W-1:0] cat;
    logic signed [CZ_W-1:0] cz_rnd;
    logic signed [ANG_W-1:0] tilt_val;
    assign ci = r_cnt - 5'd1;
    assign cxs = r_cx >>> ci;
    assign cys = r_cy >>> ci;
    assign cat = $signed({3'b0, atan_entry(ci)});
    assign cz_rnd = (r_cz + 26'sd32) >>> 6;
    always_comb begin
        if (tw == '0) begin
            tilt_val = '0;
        end else if (r_sumsq == '0) begin
            tilt_val = tw[RAW_W-1] ? -DEG90 : DEG90;
        end else begin
            tilt_val = cz_rnd[ANG_W-1:0];
        end
    end

    // Blend sum scaled back by 2^16 with rounding
    logic signed [MP_W-1:0] bsum;
    assign bsum = (r_sacc + r_prod + 58'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_sel <= '0;
            r_wjob <= WJ_GINT;
            r_ofs[0] <= '0;
            r_ofs[1] <= '0;
            r_ofs[2] <= '0;
            r_scale <= 24'd128070;
            r_awgt <= 17'd1311;
            r_gwgt <= 17'd64225;
            r_gint[0] <= '0;
            r_gint[1] <= '0;
            r_gint[2] <= '0;
            r_fused[0] <= '0;
            r_fused[1] <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= cnt_clr ? 5'd0 : r_cnt + 5'd1;

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_OFS_X: r_ofs[0] <= i_cfg_wdata[15:0];
                    CFG_OFS_Y: r_ofs[1] <= i_cfg_wdata[15:0];
                    CFG_OFS_Z: r_ofs[2] <= i_cfg_wdata[15:0];
                    CFG_SCALE: r_scale <= i_cfg_wdata;
                    CFG_AWGT:  r_awgt <= i_cfg_wdata[16:0];
                    CFG_GWGT:  r_gwgt <= i_cfg_wdata[16:0];
                    default: ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_accel[0] <= s_axis_tdata[15:0];
                        r_accel[1] <= s_axis_tdata[31:16];
                        r_accel[2] <= s_axis_tdata[47:32];
                        r_rate[0] <= s_axis_tdata[63:48];
                        r_rate[1] <= s_axis_tdata[79:64];
                        r_rate[2] <= s_axis_tdata[95:80];
                        r_ms <= s_axis_tdata[111:96];
                        r_sel <= '0;
                    end
                end
                ST_GMUL1: begin
                    r_prod <= mul_p;
                    r_neg <= diff[16];
                end
                ST_GMUL2: r_prod <= mul_p;
                ST_GDIV: begin
                    if (r_cnt == 5'd0) begin
                        r_dq <= {4'b0, r_prod[55:0]} + DQ_W'(GYRO_HALF);
                        r_rem <= '0;
                    end else if (r_cnt == 5'(DIV_STEPS + 1)) begin
                        r_inc[r_sel] <= inc_val;
                        r_wval <= WV_W'(r_gint[r_sel]) + WV_W'(inc_val);
                        r_wjob <= WJ_GINT;
                    end else begin
                        r_dq <= dv_q;
                        r_rem <= dv_r;
                    end
                end
                ST_WRAP: begin
                    if (r_cnt == 5'd0) begin
                        r_dq <= DQ_W'(wmag);
                        r_rem <= '0;
                        r_neg <= r_wval[WV_W-1];
                    end else if (r_cnt == 5'(DIV_STEPS + 1)) begin
                        case (r_wjob)
                            WJ_GINT: begin
                                r_gint[r_sel] <= wr_res;
                                r_sel <= (r_sel == 2'd2) ? 2'd0 : r_sel + 2'd1;
                            end
                            WJ_DIFF: r_d <= wr_res;
                            WJ_FUSE: begin
                                r_fused[r_sel[0]] <= wr_res;
                                if (!r_sel[0]) begin
                                    // The Y blend starts from the old Y state.
                                    r_sel <= 2'd1;
                                    r_wval <= WV_W'(r_fused[1]) + WV_W'(r_inc[1])
                                              - WV_W'(r_ty);
                                    r_wjob <= WJ_DIFF;
                                end
                            end
                            default: ;
                        endcase
                    end else begin
                        r_dq <= dv_q;
                        r_rem <= dv_r;
                    end
                end
                ST_SQ1: r_prod <= mul_p;
                ST_SQ2: begin
                    r_sumsq <= r_prod[31:0];
                    r_prod <= mul_p;
                end
                ST_SQ3: r_sumsq <= r_sumsq + r_prod[31:0];
                ST_SQRT: begin
                    if (r_cnt == 5'd0) begin
                        r_sq_n <= {r_sumsq, 16'b0};
                        r_sq_res <= '0;
                        r_sq_bit <= SQ_W'(1) << 46;
                    end else begin
                        if (r_sq_n >= sq_try) begin
                            r_sq_n <= r_sq_n - sq_try;
                            r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                        end else begin
                            r_sq_res <= r_sq_res >> 1;
                        end
                        r_sq_bit <= r_sq_bit >> 2;
                    end
                end
                ST_CORD: begin
                    if (r_cnt == 5'd0) begin
                        r_cx <= $signed({3'b0, r_sq_res[24:0]});
                        r_cy <= $signed({{4{tw[RAW_W-1]}}, tw, 8'b0});
                        r_cz <= '0;
                    end else if (r_cnt == 5'(CORD_STEPS + 1)) begin
                        if (!r_sel[0]) begin
                            r_tx <= tilt_val;
                            r_sel <= 2'd1;
                        end else begin
                            r_ty <= -tilt_val;
                            r_sel <= 2'd0;
                            r_wval <= WV_W'(r_fused[0]) + WV_W'(r_inc[0]) - WV_W'(r_tx);
                            r_wjob <= WJ_DIFF;
                        end
                    end else if (r_cy > 0) begin
                        r_cx <= r_cx + cys;
                        r_cy <= r_cy - cxs;
                        r_cz <= r_cz + cat;
                    end else begin
                        r_cx <= r_cx - cys;
                        r_cy <= r_cy + cxs;
                        r_cz <= r_cz - cat;
                    end
                end
                ST_BMUL1: r_prod <= mul_p;
                ST_BMUL2: begin
                    r_sacc <= r_prod;
                    r_prod <= mul_p;
                end
                ST_BSUM: begin
                    r_wval <= WV_W'(bsum);
                    r_wjob <= WJ_FUSE;
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ictf_chk.sv =====
// Port-level checker for the tilt filter core and its bind.
`default_nettype none
module ictf_chk import ictf_pkg::*; (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [135:0] m_axis_tdata
);

    // The core works on one sample at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (!m_axis_tvalid && !s_axis_tready))
        else $error("result or ready right after an accepted sample");

    a_ready_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
        else $error("not ready after the result transaction");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind imu_complementary_tilt_filter_core ictf_chk u_ictf_chk (.*);
`default_nettype wire
